// ===== hdl/lmeb_pkg.sv =====
// ----------------------------------------------------------------------------
// lmeb_pkg: shared types and constants of the list-mode buffer parser
// Result record, phase and code enums, and the bundle that carries up to two
// results from the decoder into the result queue.
// ----------------------------------------------------------------------------
package lmeb_pkg;

  // Depth of the result queue; it must hold at least two entries.
  localparam int QUEUE_DEPTH = 4;

  // Scale applied to the crate number when forming the module id.
  localparam logic [31:0] CRATE_SCALE = 32'd100;

  // Header lengths that a regular event may carry.
  localparam logic [4:0] HDR_LEN_4  = 5'd4;
  localparam logic [4:0] HDR_LEN_8  = 5'd8;
  localparam logic [4:0] HDR_LEN_12 = 5'd12;
  localparam logic [4:0] HDR_LEN_16 = 5'd16;

  typedef enum logic [3:0] {
    PH_LEN,
    PH_MOD,
    PH_W0,
    PH_W1,
    PH_W2,
    PH_W3,
    PH_XHDR,
    PH_TRACE,
    PH_SKIP,
    PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_TRACE,
    KIND_END
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_EMPTY,
    ST_ZERO_LEN,
    ST_BAD_HEADER,
    ST_STATS
  } status_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [3:0]  channel;
    logic [31:0] module_id;
    logic [14:0] energy;
    logic [47:0] event_time;
    logic [14:0] cfd_fraction;
    logic        finish_code;
    logic [15:0] trace_length;
    logic [31:0] sample_pair;
    status_t     buffer_status;
    logic [31:0] event_count;
    logic        last_of_run;
  } result_t;

  // Results produced by one accepted word, in delivery order.
  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } push_t;

endpackage

// ===== hdl/lmeb_if.sv =====
// ----------------------------------------------------------------------------
// lmeb_if: stream channels of the list-mode buffer parser
// Word channel into the parser and result channel out of it, each with
// valid, ready and payload.
// ----------------------------------------------------------------------------
interface lmeb_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink (input valid, input data_word, output ready);
endinterface

interface lmeb_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  channel;
  logic [31:0] module_id;
  logic [14:0] energy;
  logic [47:0] event_time;
  logic [14:0] cfd_fraction;
  logic        finish_code;
  logic [15:0] trace_length;
  logic [31:0] sample_pair;
  logic [2:0]  buffer_status;
  logic [31:0] event_count;
  logic        last_of_run;

  modport source (
    output valid, output result_kind, output channel, output module_id,
    output energy, output event_time, output cfd_fraction, output finish_code,
    output trace_length, output sample_pair, output buffer_status,
    output event_count, output last_of_run, input ready
  );
  modport sink (
    input valid, input result_kind, input channel, input module_id,
    input energy, input event_time, input cfd_fraction, input finish_code,
    input trace_length, input sample_pair, input buffer_status,
    input event_count, input last_of_run, output ready
  );
endinterface

// ===== hdl/lmeb_decoder.sv =====
// ----------------------------------------------------------------------------
// lmeb_decoder: buffer word decoder
// Holds the parse state, decodes each accepted word against it in one pass
// and hands zero, one or two results to the result queue.
// ----------------------------------------------------------------------------
module lmeb_decoder import lmeb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_wdata,
  input  logic          room,
  lmeb_word_if.sink     word_in,
  output push_t         push
);

  // Parse state.
  phase_t      phase, phase_next;
  logic [31:0] buffer_words, buffer_words_next;
  logic [31:0] words_consumed, words_consumed_next;
  logic [31:0] module_word, module_word_next;
  logic [31:0] header_fields, header_fields_next;
  logic [31:0] time_low, time_low_next;
  logic [30:0] time_high_cfd, time_high_cfd_next;
  logic [13:0] event_words_seen, event_words_seen_next;
  logic [14:0] trace_words_left, trace_words_left_next;
  logic [31:0] good_events, good_events_next;
  logic        stats_flag, stats_flag_next;
  logic [4:0]  stats_header_length;

  logic        accept;
  logic [31:0] w;
  logic [31:0] wc_inc;
  logic        buffer_done;
  logic [4:0]  hl_w, hl_h;
  logic [13:0] el_w, el_h;
  logic [15:0] tl;
  logic [14:0] trace_words;
  logic        legal_hl;
  logic        is_stats;
  logic        len_mismatch;
  logic [13:0] ews_dec;
  logic [14:0] twl_dec;

  logic        prim_valid, end_valid;
  result_t     prim, end_res;
  status_t     end_status;
  logic [31:0] end_count;

  assign word_in.ready = room;
  assign accept        = word_in.valid && room;
  assign w             = word_in.data_word;

  // Word count saturates; the buffer end is judged on the updated count.
  assign wc_inc      = (words_consumed == '1) ? words_consumed : words_consumed + 32'd1;
  assign buffer_done = wc_inc >= buffer_words;

  // Field extraction from the current word and the stored first header word.
  assign hl_w         = w[16:12];
  assign el_w         = w[30:17];
  assign hl_h         = header_fields[16:12];
  assign el_h         = header_fields[30:17];
  assign tl           = w[31:16];
  assign trace_words  = tl[15:1];
  assign legal_hl     = (hl_w == HDR_LEN_4) || (hl_w == HDR_LEN_8) ||
                        (hl_w == HDR_LEN_12) || (hl_w == HDR_LEN_16);
  assign is_stats     = hl_w == stats_header_length;
  assign len_mismatch = ({1'b0, trace_words} + {11'b0, hl_h}) != {2'b0, el_h};
  assign ews_dec      = event_words_seen - 14'd1;
  assign twl_dec      = trace_words_left - 15'd1;

  // Next-state logic.
  always_comb begin
    phase_next            = phase;
    buffer_words_next     = buffer_words;
    words_consumed_next   = wc_inc;
    module_word_next      = module_word;
    header_fields_next    = header_fields;
    time_low_next         = time_low;
    time_high_cfd_next    = time_high_cfd;
    event_words_seen_next = event_words_seen;
    trace_words_left_next = trace_words_left;
    good_events_next      = good_events;
    stats_flag_next       = stats_flag;
    unique case (phase)
      PH_LEN: begin
        buffer_words_next   = w;
        words_consumed_next = 32'd1;
        good_events_next    = '0;
        stats_flag_next     = 1'b0;
        phase_next          = PH_MOD;
      end
      PH_MOD: begin
        module_word_next = w;
        phase_next       = (buffer_words <= 32'd2) ? PH_LEN : PH_W0;
      end
      PH_W0: begin
        header_fields_next = w;
        if (is_stats) begin
          stats_flag_next = 1'b1;
          if (el_w > 14'd1) begin
            event_words_seen_next = el_w - 14'd1;
            phase_next            = PH_SKIP;
          end else begin
            phase_next = buffer_done ? PH_LEN : PH_W0;
          end
        end else if (!legal_hl) begin
          phase_next = buffer_done ? PH_LEN : PH_DRAIN;
        end else begin
          phase_next = PH_W1;
        end
      end
      PH_W1: begin
        time_low_next = w;
        phase_next    = PH_W2;
      end
      PH_W2: begin
        time_high_cfd_next = w[30:0];
        phase_next         = PH_W3;
      end
      PH_W3: begin
        if (len_mismatch) begin
          if (el_h > 14'd4) begin
            event_words_seen_next = el_h - 14'd4;
            phase_next            = PH_SKIP;
          end else begin
            phase_next = buffer_done ? PH_LEN : PH_W0;
          end
        end else begin
          good_events_next      = good_events + 32'd1;
          trace_words_left_next = trace_words;
          if (hl_h > HDR_LEN_4) begin
            event_words_seen_next = {9'b0, hl_h} - 14'd4;
            phase_next            = PH_XHDR;
          end else if (trace_words != '0) begin
            phase_next = PH_TRACE;
          end else begin
            phase_next = buffer_done ? PH_LEN : PH_W0;
          end
        end
      end
      PH_XHDR: begin
        event_words_seen_next = ews_dec;
        if (ews_dec == '0) begin
          if (trace_words_left != '0) begin
            phase_next = PH_TRACE;
          end else begin
            phase_next = buffer_done ? PH_LEN : PH_W0;
          end
        end
      end
      PH_TRACE: begin
        trace_words_left_next = twl_dec;
        if (twl_dec == '0) begin
          phase_next = buffer_done ? PH_LEN : PH_W0;
        end
      end
      PH_SKIP: begin
        event_words_seen_next = ews_dec;
        if (ews_dec == '0) begin
          phase_next = buffer_done ? PH_LEN : PH_W0;
        end
      end
      PH_DRAIN: begin
        if (buffer_done) begin
          phase_next = PH_LEN;
        end
      end
      default: begin
        phase_next = PH_LEN;
      end
    endcase
  end

  // Output logic: which results this word produces.
  always_comb begin
    prim_valid = 1'b0;
    end_valid  = 1'b0;
    end_status = stats_flag ? ST_STATS : ST_OK;
    end_count  = good_events;
    unique case (phase)
      PH_MOD: begin
        if (buffer_words == '0) begin
          end_valid  = 1'b1;
          end_status = ST_ZERO_LEN;
        end else if (buffer_words <= 32'd2) begin
          end_valid  = 1'b1;
          end_status = ST_EMPTY;
        end
      end
      PH_W0: begin
        if (is_stats) begin
          end_valid  = (el_w <= 14'd1) && buffer_done;
          end_status = ST_STATS;
        end else if (!legal_hl) begin
          end_valid  = 1'b1;
          end_status = ST_BAD_HEADER;
        end
      end
      PH_W3: begin
        if (len_mismatch) begin
          end_valid = (el_h <= 14'd4) && buffer_done;
        end else begin
          prim_valid = 1'b1;
          end_valid  = (hl_h <= HDR_LEN_4) && (trace_words == '0) && buffer_done;
          end_count  = good_events + 32'd1;
        end
      end
      PH_XHDR: begin
        end_valid = (ews_dec == '0) && (trace_words_left == '0) && buffer_done;
      end
      PH_TRACE: begin
        prim_valid = 1'b1;
        end_valid  = (twl_dec == '0) && buffer_done;
      end
      PH_SKIP: begin
        end_valid = (ews_dec == '0) && buffer_done;
      end
      default: begin
        prim_valid = 1'b0;
      end
    endcase
  end

  // Result records: event header or trace word first, buffer end after it.
  always_comb begin
    prim = '0;
    if (phase == PH_TRACE) begin
      prim.result_kind = KIND_TRACE;
      prim.sample_pair = w;
    end else begin
      prim.result_kind  = KIND_HEADER;
      prim.channel      = header_fields[3:0];
      prim.module_id    = module_word + ({28'b0, header_fields[11:8]} * CRATE_SCALE);
      prim.energy       = w[14:0];
      prim.event_time   = {time_high_cfd[15:0], time_low};
      prim.cfd_fraction = time_high_cfd[30:16];
      prim.finish_code  = header_fields[31];
      prim.trace_length = tl;
    end
    prim.last_of_run = !end_valid;

    end_res               = '0;
    end_res.result_kind   = KIND_END;
    end_res.buffer_status = end_status;
    end_res.event_count   = end_count;
    end_res.last_of_run   = 1'b1;
  end

  // Results go to the queue in order only for an accepted word.
  always_comb begin
    push.first_valid  = accept && (prim_valid || end_valid);
    push.second_valid = accept && prim_valid && end_valid;
    push.first        = prim_valid ? prim : end_res;
    push.second       = end_res;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_LEN;
      buffer_words        <= '0;
      words_consumed      <= '0;
      module_word         <= '0;
      header_fields       <= '0;
      time_low            <= '0;
      time_high_cfd       <= '0;
      event_words_seen    <= '0;
      trace_words_left    <= '0;
      good_events         <= '0;
      stats_flag          <= 1'b0;
      stats_header_length <= '0;
    end else begin
      if (cfg_we) begin
        stats_header_length <= cfg_wdata;
      end
      if (accept) begin
        phase            <= phase_next;
        buffer_words     <= buffer_words_next;
        words_consumed   <= words_consumed_next;
        module_word      <= module_word_next;
        header_fields    <= header_fields_next;
        time_low         <= time_low_next;
        time_high_cfd    <= time_high_cfd_next;
        event_words_seen <= event_words_seen_next;
        trace_words_left <= trace_words_left_next;
        good_events      <= good_events_next;
        stats_flag       <= stats_flag_next;
      end
    end
  end

endmodule

// ===== hdl/lmeb_result_queue.sv =====
// ----------------------------------------------------------------------------
// lmeb_result_queue: result register queue
// Small circular queue that takes up to two results per cycle and delivers
// one per cycle on the result channel while the consumer is ready.
// ----------------------------------------------------------------------------
module lmeb_result_queue import lmeb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  push_t           push,
  output logic            room,
  output logic [$clog2(DEPTH+1)-1:0] level,
  lmeb_result_if.source   result_out
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W-1:0] wr_p1, wr_p2, rd_p1;
  logic [CNT_W-1:0] count;
  logic             pop;
  logic [1:0]       push_n;
  result_t          head;

  // Pointer steps with wrap at the queue depth.
  assign wr_p1 = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
  assign wr_p2 = (wr_p1 == PTR_W'(DEPTH - 1)) ? '0 : wr_p1 + PTR_W'(1);
  assign rd_p1 = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);

  // Room for two entries is required before a word is taken.
  assign room   = count <= CNT_W'(DEPTH - 2);
  assign level  = count;
  assign pop    = result_out.valid && result_out.ready;
  assign push_n = {1'b0, push.first_valid} + {1'b0, push.second_valid};

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      entries[wr_p1] <= push.second;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.second_valid) begin
        wr_ptr <= wr_p2;
      end else if (push.first_valid) begin
        wr_ptr <= wr_p1;
      end
      if (pop) begin
        rd_ptr <= rd_p1;
      end
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  // Head of the queue drives the result channel.
  assign head                     = entries[rd_ptr];
  assign result_out.valid         = count != '0;
  assign result_out.result_kind   = head.result_kind;
  assign result_out.channel       = head.channel;
  assign result_out.module_id     = head.module_id;
  assign result_out.energy        = head.energy;
  assign result_out.event_time    = head.event_time;
  assign result_out.cfd_fraction  = head.cfd_fraction;
  assign result_out.finish_code   = head.finish_code;
  assign result_out.trace_length  = head.trace_length;
  assign result_out.sample_pair   = head.sample_pair;
  assign result_out.buffer_status = head.buffer_status;
  assign result_out.event_count   = head.event_count;
  assign result_out.last_of_run   = head.last_of_run;

endmodule

// ===== hdl/list_mode_event_buffer_parser_unit.sv =====
// ----------------------------------------------------------------------------
// list_mode_event_buffer_parser_unit: list-mode buffer parser
// Decodes a digitizer buffer word stream into event headers, trace sample
// pairs and buffer-end records.
// ----------------------------------------------------------------------------
//
//   Channel      Dir  Payload                               Handshake
//   word_in      in   data_word (32)                        valid / ready
//   result_out   out  result_kind .. last_of_run record     valid / ready
//   cfg_*        in   stats_header_length (5)               write enable only
//
// One word is taken per cycle while the queue has room; its results go into
// the result queue at the edge that takes the word and are offered once the
// results ahead have left. The single-read queue delivers them one at a time.
// Words are refused while the queue has fewer than two free entries.
// Reset (rst, synchronous) returns the parser to wait for a length word.
//
module list_mode_event_buffer_parser_unit import lmeb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_wdata,
  lmeb_word_if.sink     word_in,
  lmeb_result_if.source result_out
);

  push_t                      push;
  logic                       room;
  logic [$clog2(DEPTH+1)-1:0] level;

  // Word decoder and parse state.
  lmeb_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .room      (room),
    .word_in   (word_in),
    .push      (push)
  );

  // Result queue toward the output channel.
  lmeb_result_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .level      (level),
    .result_out (result_out)
  );

  // A request is only taken when the queue can absorb two results.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.first_valid |-> (level <= $bits(level)'(DEPTH - 2)))
    else $error("result pushed without queue room");

  // A second result always follows a first one and is a buffer end.
  a_second_is_end: assert property (@(posedge clk) disable iff (rst)
    push.second_valid |-> (push.first_valid && push.second.result_kind == KIND_END))
    else $error("second result is not a buffer end");

  // A buffer end is always the last result of its word.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.result_kind == KIND_END) |-> result_out.last_of_run)
    else $error("buffer end without last flag");

  // Level never exceeds the queue depth.
  a_level: assert property (@(posedge clk) disable iff (rst)
    level <= $bits(level)'(DEPTH))
    else $error("result queue overflow");

endmodule
